[rtl/lattice_decimal_multiplier_macros.svh]
// Assertion helpers shared by the lattice decimal multiplier.
// Each macro expects clk and arst_n in scope.
`ifndef LATTICE_DECIMAL_MULTIPLIER_MACROS_SVH
`define LATTICE_DECIMAL_MULTIPLIER_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define LDM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lattice decimal multiplier: next-cycle check failed");

// Consequent must hold in the same cycle as the antecedent.
`define LDM_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lattice decimal multiplier: same-cycle check failed");

`endif

[rtl/ldm_pkg.sv]
`timescale 1ns / 1ps
package ldm_pkg;

	localparam int unsigned TEN         = 10;
	// floor(x / 10) == (x * 205) >> 11 for every x below 1029
	localparam int unsigned DIV10_MUL   = 205;
	localparam int unsigned DIV10_SHIFT = 11;

	// Column sum widths, sized for up to sixteen digits per operand
	localparam int unsigned USUM_W = 8;	// up to 16 units digits of 9
	localparam int unsigned TSUM_W = 9;	// up to 16 tens digits of 22
	localparam int unsigned COL_W  = 9;	// units plus tens, at most 496

	typedef logic [3:0] digit_t;

	typedef struct packed {
		logic [4:0] tens;
		digit_t     units;
	} cell_t;

	// Register enables for the carry section
	typedef struct packed {
		logic s3;
		logic s4;
		logic s5;
	} carry_en_t;

	// Quotient by ten through a reciprocal multiply
	function automatic logic [6:0] div10(input logic [9:0] x);
		logic [20:0] m;
		m = 21'(x) * 21'(DIV10_MUL);
		return m[DIV10_SHIFT +: 7];
	endfunction

	// One lattice cell: digit product split into tens and units
	function automatic cell_t lattice_cell(input digit_t a, input digit_t b);
		logic [7:0] p;
		logic [6:0] q;
		cell_t      c;
		p       = 8'(a) * 8'(b);
		q       = div10(10'(p));
		c.tens  = q[4:0];
		c.units = 4'(p - 8'(q) * 8'(TEN));
		return c;
	endfunction

endpackage

[rtl/ldm_if.sv]
`timescale 1ns / 1ps
// Operand channel
interface ldm_in_if #(parameter int W = 60) ();
	logic         valid;
	logic         ready;
	logic [W-1:0] multiplicand_bcd;
	logic [W-1:0] multiplier_bcd;

	modport source (output valid, output multiplicand_bcd, output multiplier_bcd,
		input ready);
	modport sink (input valid, input multiplicand_bcd, input multiplier_bcd,
		output ready);
endinterface

// Product channel, one half per transfer
interface ldm_out_if #(parameter int W = 60) ();
	logic         valid;
	logic         ready;
	logic [W-1:0] product_half_bcd;
	logic         last_half;
	logic         bad_digit;

	modport source (output valid, output product_half_bcd, output last_half,
		output bad_digit, input ready);
	modport sink (input valid, input product_half_bcd, input last_half,
		input bad_digit, output ready);
endinterface

[rtl/ldm_lattice.sv]
`timescale 1ns / 1ps
module ldm_lattice
	import ldm_pkg::*;
#(
	parameter int DIGITS = 15
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic [4*DIGITS-1:0]   a,
	input  logic [4*DIGITS-1:0]   b,
	output cell_t                 cell_s1 [DIGITS][DIGITS],
	output logic                  bad_s1
);

	logic bad_c;

	// Flag any nibble above nine
	always_comb begin
		bad_c = 1'b0;
		for (int i = 0; i < DIGITS; i++) begin
			if (a[4*i +: 4] > 4'(TEN - 1) || b[4*i +: 4] > 4'(TEN - 1)) begin
				bad_c = 1'b1;
			end
		end
	end

	// Fill the lattice, one cell per digit pair
	always_ff @(posedge clk) begin
		if (en) begin
			bad_s1 <= bad_c;
			for (int i = 0; i < DIGITS; i++) begin
				for (int j = 0; j < DIGITS; j++) begin
					cell_s1[i][j] <= lattice_cell(a[4*i +: 4], b[4*j +: 4]);
				end
			end
		end
	end

endmodule

[rtl/ldm_colsum.sv]
`timescale 1ns / 1ps
module ldm_colsum
	import ldm_pkg::*;
#(
	parameter int DIGITS = 15
) (
	input  logic                  clk,
	input  logic                  en,
	input  cell_t                 cell_s1 [DIGITS][DIGITS],
	input  logic                  bad_s1,
	output logic [USUM_W-1:0]     usum_s2 [2*DIGITS],
	output logic [TSUM_W-1:0]     tsum_s2 [2*DIGITS],
	output logic                  bad_s2
);

	logic [USUM_W-1:0] usum_c [2*DIGITS];
	logic [TSUM_W-1:0] tsum_c [2*DIGITS];

	// Sum units and tens along each diagonal of the lattice
	always_comb begin
		for (int k = 0; k < 2*DIGITS; k++) begin
			usum_c[k] = '0;
			tsum_c[k] = '0;
		end
		for (int i = 0; i < DIGITS; i++) begin
			for (int j = 0; j < DIGITS; j++) begin
				usum_c[i+j] = usum_c[i+j] + USUM_W'(cell_s1[i][j].units);
				tsum_c[i+j] = tsum_c[i+j] + TSUM_W'(cell_s1[i][j].tens);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			usum_s2 <= usum_c;
			tsum_s2 <= tsum_c;
			bad_s2  <= bad_s1;
		end
	end

endmodule

[rtl/ldm_carry.sv]
`timescale 1ns / 1ps
module ldm_carry
	import ldm_pkg::*;
#(
	parameter int DIGITS = 15
) (
	input  logic                  clk,
	input  carry_en_t             en,
	input  logic [USUM_W-1:0]     usum_s2 [2*DIGITS],
	input  logic [TSUM_W-1:0]     tsum_s2 [2*DIGITS],
	input  logic                  bad_s2,
	output digit_t                prod_s5 [2*DIGITS],
	output logic                  bad_s5
);

	localparam int COLS = 2*DIGITS;

	// Stage 3 signals
	logic [COL_W-1:0] col_c [COLS];
	logic [6:0]       q0_c  [COLS];
	digit_t           u0_s3 [COLS];
	logic [5:0]       c0_s3 [COLS];
	logic             bad_s3;

	// Stage 4 signals
	logic [5:0]       s1v_c [COLS];
	logic [6:0]       q1_c  [COLS];
	digit_t           u1_c  [COLS];
	logic [2:0]       c1_c  [COLS];
	digit_t           s2v_c [COLS];
	logic             c2_c  [COLS];
	digit_t           u2_c  [COLS];
	digit_t           d_c   [COLS];
	digit_t           d_s4  [COLS];
	logic             bad_s4;

	// Stage 5 signals
	logic [COLS-1:0]  gen_c;
	logic [COLS-1:0]  prop_c;
	logic [COLS-1:0]  sum_c;
	logic [COLS-1:0]  cin_c;
	digit_t           p_c   [COLS];

	// Merge each column and split it into a units digit and a carry
	always_comb begin
		for (int k = 0; k < COLS; k++) begin
			col_c[k] = COL_W'(usum_s2[k]) + ((k > 0) ? COL_W'(tsum_s2[(k > 0) ? k-1 : 0])
				: COL_W'(0));
			q0_c[k]  = div10(10'(col_c[k]));
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			bad_s3 <= bad_s2;
			for (int k = 0; k < COLS; k++) begin
				c0_s3[k] <= 6'(q0_c[k]);
				u0_s3[k] <= 4'(col_c[k] - COL_W'(q0_c[k]) * COL_W'(TEN));
			end
		end
	end

	// Two more carry-save passes bring every digit down to at most ten
	always_comb begin
		for (int k = 0; k < COLS; k++) begin
			s1v_c[k] = 6'(u0_s3[k]) + ((k > 0) ? c0_s3[(k > 0) ? k-1 : 0] : 6'd0);
			q1_c[k]  = div10(10'(s1v_c[k]));
			c1_c[k]  = 3'(q1_c[k]);
			u1_c[k]  = 4'(s1v_c[k] - 6'(q1_c[k]) * 6'(TEN));
		end
		for (int k = 0; k < COLS; k++) begin
			s2v_c[k] = u1_c[k] + ((k > 0) ? 4'(c1_c[(k > 0) ? k-1 : 0]) : 4'd0);
			c2_c[k]  = (s2v_c[k] >= 4'(TEN));
			u2_c[k]  = c2_c[k] ? s2v_c[k] - 4'(TEN) : s2v_c[k];
		end
		for (int k = 0; k < COLS; k++) begin
			d_c[k] = u2_c[k] + ((k > 0) ? 4'(c2_c[(k > 0) ? k-1 : 0]) : 4'd0);
		end
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			bad_s4 <= bad_s3;
			d_s4   <= d_c;
		end
	end

	// Resolve single-bit carries with one binary add: a ten generates,
	// a nine propagates
	always_comb begin
		for (int k = 0; k < COLS; k++) begin
			gen_c[k]  = (d_s4[k] == 4'(TEN));
			prop_c[k] = (d_s4[k] == 4'(TEN - 1));
		end
		sum_c = (gen_c | prop_c) + gen_c;
		cin_c = sum_c ^ (gen_c | prop_c) ^ gen_c;
		for (int k = 0; k < COLS; k++) begin
			p_c[k] = d_s4[k] + 4'(cin_c[k]);
			if (p_c[k] >= 4'(TEN)) begin
				p_c[k] = p_c[k] - 4'(TEN);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.s5) begin
			bad_s5  <= bad_s4;
			prod_s5 <= p_c;
		end
	end

endmodule

[rtl/ldm_outbuf.sv]
`timescale 1ns / 1ps
module ldm_outbuf
	import ldm_pkg::*;
#(
	parameter int DIGITS = 15
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  digit_t        prod_s5 [2*DIGITS],
	input  logic          bad_s5,
	output logic          free,
	ldm_out_if.source     product
);

	logic                valid_q;
	logic                phase_q;
	logic                bad_q;
	logic [4*DIGITS-1:0] hi_q;
	logic [4*DIGITS-1:0] lo_q;
	logic                xfer;

	assign xfer = valid_q & product.ready;
	assign free = ~valid_q | (product.ready & phase_q);

	// Track which half is on offer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
			phase_q <= 1'b0;
		end else if (xfer) begin
			if (phase_q) begin
				valid_q <= 1'b0;
			end
			phase_q <= ~phase_q;
		end
	end

	// Capture both halves of the product
	always_ff @(posedge clk) begin
		if (load) begin
			bad_q <= bad_s5;
			for (int i = 0; i < DIGITS; i++) begin
				lo_q[4*i +: 4] <= prod_s5[i];
				hi_q[4*i +: 4] <= prod_s5[DIGITS + i];
			end
		end
	end

	assign product.valid            = valid_q;
	assign product.product_half_bcd = phase_q ? lo_q : hi_q;
	assign product.last_half        = phase_q;
	assign product.bad_digit        = bad_q;

endmodule

[rtl/lattice_decimal_multiplier.sv]
`timescale 1ns / 1ps
// Channel    Dir  Payload                                          Beats per pair
// operands   in   multiplicand_bcd, multiplier_bcd (4*DIGITS each)  1
// product    out  product_half_bcd, last_half, bad_digit           2 (high, then low)
//
// Five pipeline stages (lattice, diagonal sums, column split, carry-save passes,
// carry resolve) feed a two-beat output register that offers the high half once a
// product is loaded from the last stage. Serving both halves of a product on one
// port, it takes a new product only when empty or as the low half of the last leaves.
// Stalls ripple back through per-stage ready; a stalled stage holds its data.
// Reset clears the valid bits and the output phase only.
`include "lattice_decimal_multiplier_macros.svh"
module lattice_decimal_multiplier
	import ldm_pkg::*;
#(
	parameter int DIGITS = 15
) (
	input  logic      clk,
	input  logic      arst_n,
	ldm_in_if.sink    operands,
	ldm_out_if.source product
);

	cell_t             cell_s1 [DIGITS][DIGITS];
	logic              bad_s1;
	logic [USUM_W-1:0] usum_s2 [2*DIGITS];
	logic [TSUM_W-1:0] tsum_s2 [2*DIGITS];
	logic              bad_s2;
	digit_t            prod_s5 [2*DIGITS];
	logic              bad_s5;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	logic buf_free;
	logic load;
	carry_en_t carry_en;

	// Per-stage ready: a stage may load when empty or when it moves on
	assign rdy5 = ~v_s5 | buf_free;
	assign rdy4 = ~v_s4 | rdy5;
	assign rdy3 = ~v_s3 | rdy4;
	assign rdy2 = ~v_s2 | rdy3;
	assign rdy1 = ~v_s1 | rdy2;
	assign load = v_s5 & buf_free;

	assign operands.ready = rdy1;

	assign carry_en.s3 = rdy3 & v_s2;
	assign carry_en.s4 = rdy4 & v_s3;
	assign carry_en.s5 = rdy5 & v_s4;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= operands.valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	ldm_lattice #(.DIGITS(DIGITS)) u_lattice (
		.clk     (clk),
		.en      (rdy1 & operands.valid),
		.a       (operands.multiplicand_bcd),
		.b       (operands.multiplier_bcd),
		.cell_s1 (cell_s1),
		.bad_s1  (bad_s1)
	);

	ldm_colsum #(.DIGITS(DIGITS)) u_colsum (
		.clk     (clk),
		.en      (rdy2 & v_s1),
		.cell_s1 (cell_s1),
		.bad_s1  (bad_s1),
		.usum_s2 (usum_s2),
		.tsum_s2 (tsum_s2),
		.bad_s2  (bad_s2)
	);

	ldm_carry #(.DIGITS(DIGITS)) u_carry (
		.clk     (clk),
		.en      (carry_en),
		.usum_s2 (usum_s2),
		.tsum_s2 (tsum_s2),
		.bad_s2  (bad_s2),
		.prod_s5 (prod_s5),
		.bad_s5  (bad_s5)
	);

	ldm_outbuf #(.DIGITS(DIGITS)) u_outbuf (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (load),
		.prod_s5 (prod_s5),
		.bad_s5  (bad_s5),
		.free    (buf_free),
		.product (product)
	);

	// A stalled last stage keeps its item
	`LDM_ASSERT_NEXT(a_s5_hold, v_s5 && !buf_free, v_s5)
	// The low half follows the high half at once, with the same error flag
	`LDM_ASSERT_NEXT(a_low_follows, product.valid && product.ready && !product.last_half,
		product.valid && product.last_half && $stable(product.bad_digit))
	// A new product only replaces an empty buffer or a finishing low half
	`LDM_ASSERT_SAME(a_load_free, load, !product.valid || product.last_half)

endmodule

[tb/lattice_decimal_multiplier_test.sv]
`timescale 1ns / 1ps
module lattice_decimal_multiplier_test;
	import ldm_pkg::*;

	localparam int DIGITS       = 15;
	localparam int W            = 4 * DIGITS;
	localparam int RANDOM_PAIRS = 1280;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DIRECTED_N   = 17;

	localparam logic [W-1:0] ALL_NINES = 60'h999999999999999;

	// One product half as it leaves the block
	typedef struct {
		logic [W-1:0] digits;
		logic         last;
		logic         bad;
	} half_t;

	// One operand pair; known rows carry a hand-typed product
	typedef struct {
		logic [W-1:0] a;
		logic [W-1:0] b;
		bit           known;
		logic [W-1:0] hi;
		logic [W-1:0] lo;
		logic         bad;
	} pair_t;

	logic clk;
	logic arst_n;
	int   errors;
	int   cycles;
	int   src_calm;
	int   snk_calm;

	half_t expected_halves[$];
	pair_t pending_pairs[$];

	ldm_in_if #(.W(W)) operands ();
	ldm_out_if #(.W(W)) product ();

	lattice_decimal_multiplier #(.DIGITS(DIGITS)) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.operands(operands),
		.product (product)
	);

	pair_t directed [DIRECTED_N] = '{
		'{60'h0, 60'h0, 1'b1, 60'h0, 60'h0, 1'b0},
		'{60'h1, 60'h1, 1'b1, 60'h0, 60'h1, 1'b0},
		'{ALL_NINES, ALL_NINES, 1'b1, 60'h999999999999998, 60'h000000000000001, 1'b0},
		'{60'h1, ALL_NINES, 1'b1, 60'h0, ALL_NINES, 1'b0},
		'{ALL_NINES, 60'h0, 1'b1, 60'h0, 60'h0, 1'b0},
		'{60'h9, 60'h9, 1'b1, 60'h0, 60'h81, 1'b0},
		'{60'h100000000000000, 60'h100000000000000, 1'b1, 60'h010000000000000, 60'h0,
			1'b0},
		'{60'h100000000000000, ALL_NINES, 1'b0, 60'h0, 60'h0, 1'b0},
		'{60'h123456789012345, 60'h987654321098765, 1'b0, 60'h0, 60'h0, 1'b0},
		'{60'h555555555555555, 60'h222222222222222, 1'b0, 60'h0, 60'h0, 1'b0},
		'{60'h050505050505050, 60'h090909090909090, 1'b0, 60'h0, 60'h0, 1'b0},
		// nibbles above nine, including a carry out of the top digit
		'{60'hFFFFFFFFFFFFFFF, 60'hFFFFFFFFFFFFFFF, 1'b0, 60'h0, 60'h0, 1'b0},
		'{60'h00000000000000A, 60'h1, 1'b0, 60'h0, 60'h0, 1'b0},
		'{60'h1, 60'hA00000000000000, 1'b0, 60'h0, 60'h0, 1'b0},
		'{60'hF, 60'hF, 1'b0, 60'h0, 60'h0, 1'b0},
		'{60'hAAAAAAAAAAAAAAA, 60'h555555555555555, 1'b0, 60'h0, 60'h0, 1'b0},
		'{ALL_NINES, 60'hF00000000000000, 1'b0, 60'h0, 60'h0, 1'b0}
	};

	// Form the lattice, sum the diagonals, resolve decimal carries
	function automatic void lattice_product(input logic [W-1:0] a, input logic [W-1:0] b,
		output logic [W-1:0] hi, output logic [W-1:0] lo, output logic bad);
		int unsigned col [2*DIGITS];
		int unsigned p;
		int unsigned v;
		int unsigned carry;
		int          i;
		int          j;
		bad   = 1'b0;
		hi    = '0;
		lo    = '0;
		carry = 0;
		for (i = 0; i < 2 * DIGITS; i++)
			col[i] = 0;
		for (i = 0; i < DIGITS; i++) begin
			if (a[4*i +: 4] > 4'd9 || b[4*i +: 4] > 4'd9)
				bad = 1'b1;
		end
		for (i = 0; i < DIGITS; i++) begin
			for (j = 0; j < DIGITS; j++) begin
				p = int'(a[4*i +: 4]) * int'(b[4*j +: 4]);
				col[i + j]     += p % 10;
				col[i + j + 1] += p / 10;
			end
		end
		// any carry out of the top column is dropped
		for (i = 0; i < 2 * DIGITS; i++) begin
			v     = col[i] + carry;
			carry = v / 10;
			if (i < DIGITS)
				lo[4*i +: 4] = 4'(v % 10);
			else
				hi[4*(i-DIGITS) +: 4] = 4'(v % 10);
		end
	endfunction

	// Mostly clean BCD of random length, some all-nines, zero or bad nibbles
	function automatic logic [W-1:0] random_operand();
		logic [W-1:0] v;
		int           len;
		int           mode;
		int           i;
		v    = '0;
		mode = $urandom_range(0, 19);
		len  = ($urandom_range(0, 3) == 0) ? DIGITS : $urandom_range(1, DIGITS);
		if (mode == 3)
			len = 0;
		for (i = 0; i < len; i++) begin
			if (mode == 0)
				v[4*i +: 4] = 4'd9;
			else if (mode == 1)
				v[4*i +: 4] = 4'($urandom_range(0, 15));
			else if (mode == 2 && $urandom_range(0, 7) == 0)
				v[4*i +: 4] = 4'($urandom_range(10, 15));
			else
				v[4*i +: 4] = 4'($urandom_range(0, 9));
		end
		return v;
	endfunction

	// Draw a random idle gap, with occasional stretches of back-to-back traffic
	function automatic int draw_gap(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) begin
			calm = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 10);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at cycle %0d: %s", cycles, msg);
		errors++;
	endtask

	// Offer one operand pair and hold it until the transfer
	task automatic send_operands(input pair_t pair);
		int gap;
		gap = draw_gap(src_calm);
		pending_pairs.push_back(pair);
		if (gap != 0) begin
			operands.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		operands.valid            <= 1'b1;
		operands.multiplicand_bcd <= pair.a;
		operands.multiplier_bcd   <= pair.b;
		@(posedge clk);
		while (!operands.ready)
			@(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
	end

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Bound the run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Predict both halves on every operand transfer
	always @(posedge clk) begin
		pair_t        pair;
		half_t        h;
		logic [W-1:0] hi;
		logic [W-1:0] lo;
		logic         bad;
		if (arst_n && operands.valid && operands.ready) begin
			if (pending_pairs.size() != 0 && pending_pairs[0].known) begin
				pair = pending_pairs.pop_front();
				hi   = pair.hi;
				lo   = pair.lo;
				bad  = pair.bad;
			end else begin
				if (pending_pairs.size() != 0)
					void'(pending_pairs.pop_front());
				lattice_product(operands.multiplicand_bcd, operands.multiplier_bcd, hi, lo,
					bad);
			end
			h.digits = hi;
			h.last   = 1'b0;
			h.bad    = bad;
			expected_halves.push_back(h);
			h.digits = lo;
			h.last   = 1'b1;
			expected_halves.push_back(h);
		end
	end

	// Check every product transfer against the oldest expectation
	always @(posedge clk) begin
		half_t h;
		if (arst_n && product.valid && product.ready) begin
			if (expected_halves.size() == 0) begin
				report_mismatch($sformatf("unexpected half %h last=%b",
					product.product_half_bcd, product.last_half));
			end else begin
				h = expected_halves.pop_front();
				if (product.product_half_bcd !== h.digits)
					report_mismatch($sformatf("digits %h, expected %h (last=%b)",
						product.product_half_bcd, h.digits, h.last));
				if (product.last_half !== h.last)
					report_mismatch($sformatf("last_half %b, expected %b",
						product.last_half, h.last));
				if (product.bad_digit !== h.bad)
					report_mismatch($sformatf("bad_digit %b, expected %b",
						product.bad_digit, h.bad));
			end
		end
	end

	// Product side: stall at random before each transfer
	initial begin
		int gap;
		product.ready = 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			gap = draw_gap(snk_calm);
			if (gap != 0) begin
				product.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			product.ready <= 1'b1;
			@(posedge clk);
			while (!product.valid)
				@(posedge clk);
		end
	end

	// Reset, directed table, random pairs, drain
	initial begin
		pair_t pair;
		int    n;
		arst_n                    = 1'b0;
		operands.valid            = 1'b0;
		operands.multiplicand_bcd = '0;
		operands.multiplier_bcd   = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (n = 0; n < DIRECTED_N; n++)
			send_operands(directed[n]);

		for (n = 0; n < RANDOM_PAIRS; n++) begin
			pair.a     = random_operand();
			pair.b     = random_operand();
			pair.known = 1'b0;
			pair.hi    = '0;
			pair.lo    = '0;
			pair.bad   = 1'b0;
			send_operands(pair);
		end

		operands.valid <= 1'b0;
		@(posedge clk);
		while (expected_halves.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0 && expected_halves.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/ldm_pkg.sv
rtl/ldm_if.sv
rtl/ldm_lattice.sv
rtl/ldm_colsum.sv
rtl/ldm_carry.sv
rtl/ldm_outbuf.sv
rtl/lattice_decimal_multiplier.sv
tb/lattice_decimal_multiplier_test.sv
